### rtl/core/assert_macros.svh
// Assertion macros shared by the encoder queue and back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AST_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define AST_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the following cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/x86e_pkg.sv
// Types, codes and constant tables of the x86-64 instruction encoder.
package x86e_pkg;

  // Action codes
  localparam logic [3:0] ACT_PROLOGUE = 4'd0;
  localparam logic [3:0] ACT_ADD      = 4'd1;
  localparam logic [3:0] ACT_SUB      = 4'd2;
  localparam logic [3:0] ACT_XOR      = 4'd3;
  localparam logic [3:0] ACT_ROTL     = 4'd4;
  localparam logic [3:0] ACT_ROTR     = 4'd5;
  localparam logic [3:0] ACT_BSWAP    = 4'd6;
  localparam logic [3:0] ACT_LOAD     = 4'd7;
  localparam logic [3:0] ACT_STORE    = 4'd8;
  localparam logic [3:0] ACT_EPILOGUE = 4'd9;

  localparam logic [3:0] VREG_INVALID = 4'd15;

  // Opcode bytes
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_SUB      = 8'h29;
  localparam logic [7:0] OP_XOR      = 8'h31;
  localparam logic [7:0] OP_ROT_IMM  = 8'hC1;
  localparam logic [7:0] OP_ESCAPE   = 8'h0F;
  localparam logic [7:0] OP_LOAD     = 8'h8B;
  localparam logic [7:0] OP_STORE    = 8'h89;
  localparam logic [7:0] SIB_RSP_BASE = 8'h24;

  localparam int MAX_BYTES = 13;
  localparam int LEN_W     = 4;

  typedef logic [MAX_BYTES-1:0][7:0] byte_buf_t;

  // Prologue and epilogue byte strings, first byte at index 0
  localparam byte_buf_t PROLOGUE_SYSV = {8'h00, 8'h00, 8'h00,
    8'h57, 8'h41, 8'h56, 8'h41, 8'h55, 8'h41, 8'h54, 8'h41, 8'h55, 8'h53};
  localparam byte_buf_t PROLOGUE_WIN = {8'h00,
    8'h57, 8'h41, 8'h56, 8'h41, 8'h55, 8'h41, 8'h54, 8'h41, 8'h57, 8'h56, 8'h55, 8'h53};
  localparam byte_buf_t EPILOGUE_SYSV = {8'h00, 8'h00,
    8'hC3, 8'h5B, 8'h5D, 8'h5C, 8'h41, 8'h5D, 8'h41, 8'h5E, 8'h41, 8'h5F, 8'h41};
  localparam byte_buf_t EPILOGUE_WIN = {
    8'hC3, 8'h5B, 8'h5D, 8'h5E, 8'h5F, 8'h5C, 8'h41, 8'h5D, 8'h41, 8'h5E, 8'h41, 8'h5F, 8'h41};

  localparam logic [LEN_W-1:0] PROLOGUE_SYSV_LEN = 4'd10;
  localparam logic [LEN_W-1:0] PROLOGUE_WIN_LEN  = 4'd12;
  localparam logic [LEN_W-1:0] EPILOGUE_SYSV_LEN = 4'd11;
  localparam logic [LEN_W-1:0] EPILOGUE_WIN_LEN  = 4'd13;

  // Virtual to machine register maps, entry 15 unused
  localparam logic [15:0][3:0] MAP_SYSV = {4'd0, 4'd7, 4'd6, 4'd2, 4'd1, 4'd8, 4'd9,
    4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd5, 4'd3, 4'd0};
  localparam logic [15:0][3:0] MAP_WIN = {4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd15, 4'd14,
    4'd13, 4'd12, 4'd11, 4'd10, 4'd7, 4'd6, 4'd5, 4'd3, 4'd0};

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] dst_reg;
    logic [3:0] src_reg;
    logic [3:0] base_reg;
    logic [5:0] shift_count;
    logic [6:0] displacement;
  } x86e_in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
    logic       bad_register;
  } x86e_out_t;

  // One encoded instruction as it waits in the queue
  typedef struct packed {
    byte_buf_t        bytes;
    logic [LEN_W-1:0] len;
    logic             bad;
  } x86e_entry_t;

  function automatic logic [3:0] hw_reg(input logic [3:0] v, input logic win);
    hw_reg = win ? MAP_WIN[v] : MAP_SYSV[v];
  endfunction

  function automatic logic [7:0] rex_w(input logic [3:0] r, input logic [3:0] m);
    rex_w = {4'h4, 1'b1, r[3], 1'b0, m[3]};
  endfunction

endpackage

### rtl/core/x86_64_instruction_encoder.sv
// x86-64 instruction encoder. One abstract instruction goes in per accepted item and its
// machine code comes out one byte per result item, last byte marked. The front end encodes
// an item in the cycle it is accepted and pushes the whole byte string into a queue of
// QUEUE_DEPTH entries; it takes a new item every cycle while the queue has room. The back
// end emits one byte per cycle while out_stall is low. An item has 3 bytes for
// add/sub/xor/bswap, 4 for rotates, 3 to 5 for loads and stores, 10 or 12 for the
// prologue, 11 or 13 for the epilogue, 1 for a flagged bad register. Unused action codes
// are accepted and give no output. windows_abi selects the register map; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module x86_64_instruction_encoder import x86e_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  x86e_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output x86e_out_t out_item
);

  logic        windows_abi;
  logic        q_full, q_not_empty, push, pop;
  x86e_entry_t push_entry, q_head;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      windows_abi <= 1'b0;
    end else if (cfg_wr_en) begin
      windows_abi <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;

  x86e_front u_front (
    .windows_abi (windows_abi),
    .item        (in_item),
    .accept      (in_valid && !q_full),
    .push        (push),
    .entry       (push_entry)
  );

  x86e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  x86e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

### rtl/core/x86e_front.sv
// Front end: classifies one instruction and builds its complete byte string.
module x86e_front import x86e_pkg::*; (
  input  logic        windows_abi,
  input  x86e_in_t    item,
  input  logic        accept,
  output logic        push,
  output x86e_entry_t entry
);

  logic [3:0] d, s, b, r_mem;
  logic       bad, known, has8, sib;
  logic [7:0] disp_byte;

  // Map virtual registers
  assign d = hw_reg(item.dst_reg, windows_abi);
  assign s = hw_reg(item.src_reg, windows_abi);
  assign b = hw_reg(item.base_reg, windows_abi);
  assign r_mem = (item.action == ACT_STORE) ? s : d;

  // Memory operand form
  assign has8 = (item.displacement != 7'd0) || (b[2:0] == 3'd5);
  assign sib = (b[2:0] == 3'd4);
  assign disp_byte = {1'b0, item.displacement};

  // Flag used registers that are out of range
  always_comb begin
    bad = 1'b0;
    known = 1'b1;
    case (item.action)
      ACT_PROLOGUE, ACT_EPILOGUE: bad = 1'b0;
      ACT_ADD, ACT_SUB, ACT_XOR:
        bad = (item.dst_reg == VREG_INVALID) || (item.src_reg == VREG_INVALID);
      ACT_ROTL, ACT_ROTR, ACT_BSWAP: bad = (item.dst_reg == VREG_INVALID);
      ACT_LOAD: bad = (item.dst_reg == VREG_INVALID) || (item.base_reg == VREG_INVALID);
      ACT_STORE: bad = (item.src_reg == VREG_INVALID) || (item.base_reg == VREG_INVALID);
      default: known = 1'b0;
    endcase
  end

  // Build the byte string
  always_comb begin
    entry = '0;
    case (item.action)
      ACT_PROLOGUE: begin
        entry.bytes = windows_abi ? PROLOGUE_WIN : PROLOGUE_SYSV;
        entry.len = windows_abi ? PROLOGUE_WIN_LEN : PROLOGUE_SYSV_LEN;
      end
      ACT_EPILOGUE: begin
        entry.bytes = windows_abi ? EPILOGUE_WIN : EPILOGUE_SYSV;
        entry.len = windows_abi ? EPILOGUE_WIN_LEN : EPILOGUE_SYSV_LEN;
      end
      ACT_ADD, ACT_SUB, ACT_XOR: begin
        entry.bytes[0] = rex_w(s, d);
        entry.bytes[1] = (item.action == ACT_ADD) ? OP_ADD :
                         ((item.action == ACT_SUB) ? OP_SUB : OP_XOR);
        entry.bytes[2] = {2'b11, s[2:0], d[2:0]};
        entry.len = 4'd3;
      end
      ACT_ROTL, ACT_ROTR: begin
        entry.bytes[0] = rex_w(4'd0, d);
        entry.bytes[1] = OP_ROT_IMM;
        entry.bytes[2] = {2'b11, 2'b00, item.action == ACT_ROTR, d[2:0]};
        entry.bytes[3] = {2'b00, item.shift_count};
        entry.len = 4'd4;
      end
      ACT_BSWAP: begin
        entry.bytes[0] = rex_w(4'd0, d);
        entry.bytes[1] = OP_ESCAPE;
        entry.bytes[2] = {5'b11001, d[2:0]};
        entry.len = 4'd3;
      end
      ACT_LOAD, ACT_STORE: begin
        entry.bytes[0] = rex_w(r_mem, b);
        entry.bytes[1] = (item.action == ACT_LOAD) ? OP_LOAD : OP_STORE;
        entry.bytes[2] = {1'b0, has8, r_mem[2:0], b[2:0]};
        if (sib) begin
          entry.bytes[3] = SIB_RSP_BASE;
          entry.bytes[4] = has8 ? disp_byte : 8'h00;
        end else begin
          entry.bytes[3] = has8 ? disp_byte : 8'h00;
        end
        entry.len = 4'd3 + {3'b000, sib} + {3'b000, has8};
      end
      default: entry = '0;
    endcase
    // A bad register replaces the whole string by one flagged zero byte
    if (bad) begin
      entry.bytes = '0;
      entry.len = 4'd1;
      entry.bad = 1'b1;
    end
  end

  // Drop unused action codes
  assign push = accept && known;

endmodule

### rtl/core/x86e_queue.sv
// Short queue of encoded instructions between front and back.
`include "assert_macros.svh"
module x86e_queue import x86e_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  x86e_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output x86e_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  x86e_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AST_HOLDS(a_count_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `AST_IMPLIES(a_no_pop_empty, pop, not_empty, "pop from empty queue")

endmodule

### rtl/core/x86e_back.sv
// Back end: emits the bytes of each queued instruction one per cycle while the output is not stalled.
`include "assert_macros.svh"
module x86e_back import x86e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  x86e_entry_t q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output x86e_out_t   out_item
);

  logic             busy;
  byte_buf_t        bytes;
  logic [LEN_W-1:0] left;
  logic             bad;
  logic             take, done;

  assign take = busy && !out_stall;
  assign done = take && (left == 4'd1);
  assign pop = q_not_empty && (!busy || done);

  assign out_valid = busy;
  assign out_item.code_byte = bytes[0];
  assign out_item.last_byte = (left == 4'd1);
  assign out_item.bad_register = bad;

  // Hold the byte string, shift on each taken byte
  always_ff @(posedge clk) begin
    if (pop) begin
      bytes <= q_head.bytes;
      bad <= q_head.bad;
    end else if (take) begin
      bytes <= bytes >> 8;
    end
  end

  // Track busy and bytes left
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      left <= q_head.len;
    end else if (take) begin
      left <= left - 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  `AST_IMPLIES(a_busy_left, busy, left != '0, "busy with no bytes left")
  `AST_IMPLIES(a_bad_single, busy && bad, left == 4'd1, "flagged item longer than one byte")
  `AST_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_item),
            "output changed while stalled")

endmodule
